// ===== design/dsts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsts_pkg: shared types and constants for the stump threshold search
// Sample and result beat layouts, stored record, controller commands and
// datapath status, and saturating Q1.24 helpers.
// ----------------------------------------------------------------------------
package dsts_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 1024;
  localparam int unsigned WGT_W = 25;
  localparam logic [WGT_W-1:0] Q_ONE = 25'h100_0000;

  // input beat
  typedef struct packed {
    logic signed [31:0] feature_value;
    logic               is_positive;
    logic [WGT_W-1:0]   sample_weight;
    logic               last_sample;
  } sample_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] threshold;
    logic               polarity;
    logic [WGT_W-1:0]   min_error;
    logic               found;
  } result_t;

  // one stored sample
  typedef struct packed {
    logic signed [31:0] value;
    logic               label;
    logic [WGT_W-1:0]   weight;
  } rec_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic sort_init;
    logic ins_begin;
    logic ins_fetch;
    logic ins_shift;
    logic ins_place;
    logic scan_init;
    logic scan_issue;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ins_done;
    logic pos_zero;
    logic greater;
    logic scan_done;
    logic pipe_busy;
  } stat_t;

  // saturating add at 1.0
  function automatic logic [WGT_W-1:0] sat_add(input logic [WGT_W-1:0] a,
                                               input logic [WGT_W-1:0] b);
    logic [WGT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, Q_ONE}) ? Q_ONE : s[WGT_W-1:0];
  endfunction

  // clamp at 1.0
  function automatic logic [WGT_W-1:0] sat_one(input logic [WGT_W-1:0] a);
    return (a > Q_ONE) ? Q_ONE : a;
  endfunction

endpackage
`default_nettype wire

// ===== design/dsts_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsts_datapath: sample store, insertion sort and error scan
// Holds the sample memory, the sort and scan counters, the running sums and
// the three-stage scan pipeline that tracks the best split.
// ----------------------------------------------------------------------------
module dsts_datapath #(
  parameter int unsigned MAX_SAMPLES = dsts_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dsts_pkg::cmd_t    cmd,
  input  wire dsts_pkg::sample_t sample,
  input  wire logic [24:0]       error_limit,
  output dsts_pkg::stat_t        stat,
  output dsts_pkg::result_t      result
);
  import dsts_pkg::*;

  localparam int unsigned AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

  rec_t mem [MAX_SAMPLES];
  rec_t rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  rec_t          wr_data;

  logic [CW-1:0] count;
  logic [CW-1:0] ins_i;
  logic [CW-1:0] pos_j;
  logic [CW-1:0] scan_k;
  rec_t          cur;
  logic [WGT_W-1:0] tot_p, tot_n;

  // scan pipeline
  logic             v1, v2, v3;
  logic [WGT_W-1:0] sp, sn;
  logic signed [31:0] val_a, val_b;
  logic [WGT_W-1:0] em_q, ep_q;
  logic [WGT_W-1:0] best;
  logic signed [31:0] thr;
  logic             pol;
  logic             found;

  logic [CW-1:0]    pos_m1, pos_m2;
  logic [WGT_W-1:0] load_w;

  assign pos_m1 = pos_j - CW'(1);
  assign pos_m2 = pos_j - CW'(2);
  assign load_w = sat_one(sample.sample_weight);

  // read address select
  always_comb begin
    if (cmd.ins_begin) begin
      rd_addr = ins_i[AW-1:0];
    end else if (cmd.ins_fetch) begin
      rd_addr = pos_m1[AW-1:0];
    end else if (cmd.ins_shift) begin
      rd_addr = pos_m2[AW-1:0];
    end else begin
      rd_addr = scan_k[AW-1:0];
    end
  end

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_j[AW-1:0];
    wr_data = cur;
    if (cmd.load) begin
      wr_en   = (count < MAX_CNT);
      wr_addr = count[AW-1:0];
      wr_data = '{value: sample.feature_value, label: sample.is_positive, weight: load_w};
    end else if (cmd.ins_shift) begin
      wr_en   = 1'b1;
      wr_data = rd_q;
    end else if (cmd.ins_place) begin
      wr_en   = 1'b1;
    end
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // load count and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      tot_p <= '0;
      tot_n <= '0;
    end else if (cmd.clear) begin
      count <= '0;
      tot_p <= '0;
      tot_n <= '0;
    end else if (cmd.load && (count < MAX_CNT)) begin
      count <= count + CW'(1);
      if (sample.is_positive) begin
        tot_p <= sat_add(tot_p, load_w);
      end else begin
        tot_n <= sat_add(tot_n, load_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      ins_i <= CW'(1);
    end else if (cmd.ins_place) begin
      ins_i <= ins_i + CW'(1);
    end
    if (cmd.ins_begin) begin
      pos_j <= ins_i;
    end else if (cmd.ins_shift) begin
      pos_j <= pos_m1;
    end
    if (cmd.ins_fetch) begin
      cur <= rd_q;
    end
  end

  // scan stage a: running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.scan_issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_k <= '0;
      sp     <= '0;
      sn     <= '0;
    end else begin
      if (cmd.scan_issue) begin
        scan_k <= scan_k + CW'(1);
      end
      if (v1) begin
        if (rd_q.label) begin
          sp <= sat_add(sp, rd_q.weight);
        end else begin
          sn <= sat_add(sn, rd_q.weight);
        end
      end
    end
    val_a <= rd_q.value;
  end

  // scan stage b: both polarity errors
  always_ff @(posedge clk) begin
    em_q  <= sat_add(sp, tot_n - sn);
    ep_q  <= sat_add(sn, tot_p - sp);
    val_b <= val_a;
  end

  // scan stage c: best split
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      best  <= error_limit;
      thr   <= '0;
      pol   <= 1'b0;
      found <= 1'b0;
    end else if (v3) begin
      if (em_q < ep_q) begin
        if (em_q < best) begin
          best  <= em_q;
          thr   <= val_b;
          pol   <= 1'b0;
          found <= 1'b1;
        end
      end else if (ep_q < best) begin
        best  <= ep_q;
        thr   <= val_b;
        pol   <= 1'b1;
        found <= 1'b1;
      end
    end
  end

  assign stat.ins_done  = (ins_i >= count);
  assign stat.pos_zero  = (pos_j == '0);
  assign stat.greater   = (rd_q.value > cur.value);
  assign stat.scan_done = (scan_k >= count);
  assign stat.pipe_busy = v1 | v2 | v3;

  assign result.threshold = thr;
  assign result.polarity  = pol;
  assign result.min_error = sat_one(best);
  assign result.found     = found;

endmodule
`default_nettype wire

// ===== design/dsts_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dsts_ctrl: sequencer for load, sort, scan and result
// Accepts sample beats while idle, then steps the datapath through the
// insertion sort and the error scan and strobes the result.
// ----------------------------------------------------------------------------
module dsts_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            last_sample,
  input  wire dsts_pkg::stat_t stat,
  output dsts_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 done
);
  import dsts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_NEXT, S_FETCH, S_CMP, S_SCAN, S_DRAIN, S_EMIT
  } state_t;

  state_t state, state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_sample) begin
            cmd.sort_init = 1'b1;
            state_next    = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (stat.ins_done) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          cmd.ins_begin = 1'b1;
          state_next    = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.ins_fetch = 1'b1;
        state_next    = S_CMP;
      end
      S_CMP: begin
        if (!stat.pos_zero && stat.greater) begin
          cmd.ins_shift = 1'b1;
        end else begin
          cmd.ins_place = 1'b1;
          state_next    = S_NEXT;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_DRAIN;
        end else begin
          cmd.scan_issue = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.clear  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_EMIT);

endmodule
`default_nettype wire

// ===== design/decision_stump_threshold_search_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decision_stump_threshold_search_unit: weak-learner threshold search
// Loads one sample beat per cycle while idle; the beat marked last starts
// an in-memory stable insertion sort and a pipelined scan for the lowest
// weighted error. The sort makes at most n*(n-1)/2 insertion moves through
// the memory's single read port and single write port.
// Result strobes for one cycle; the receiver cannot stall it.
// Reset clears the controller, counts and totals, error_limit returns to 1.0.
// ----------------------------------------------------------------------------
module decision_stump_threshold_search_unit #(
  parameter int unsigned MAX_SAMPLES = dsts_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // sample channel
  input  wire logic              start,
  output logic                   busy,
  input  wire dsts_pkg::sample_t sample,
  // result channel
  output logic                   done,
  output dsts_pkg::result_t      result,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import dsts_pkg::*;

  localparam logic [2:0] ADDR_ERROR_LIMIT = 3'd0;

  logic [24:0] error_limit;
  cmd_t        cmd;
  stat_t       stat;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit <= Q_ONE;
    end else if (psel && penable && pwrite && (paddr == ADDR_ERROR_LIMIT)) begin
      error_limit <= pwdata[24:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ERROR_LIMIT) ? {7'd0, error_limit} : 32'd0;

  dsts_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_sample (sample.last_sample),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy),
    .done        (done)
  );

  dsts_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sample      (sample),
    .error_limit (error_limit),
    .stat        (stat),
    .result      (result)
  );

endmodule
`default_nettype wire
